// ===== rtl/c2d_pkg.sv =====
package c2d_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int KSIZE      = 3;

    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int RSUM_W  = PROD_W + 2;
    localparam int SUM_W   = RSUM_W + 2;
    localparam int RES_W   = 35;

    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 13;
    localparam int KROW_W  = KSIZE * COEF_W;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);

    localparam int LINE_W  = 2 * PIX_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERN_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERN_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERN_BOT   = 3'd4;

    typedef logic signed [PIX_W-1:0]  t_pix;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [RSUM_W-1:0] t_rsum;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [RES_W-1:0]  t_res;

    typedef struct packed {
        logic emit;
        logic last;
        logic row_end;
        logic m_top;
        logic m_bot;
        logic m_left;
    } t_flags;

endpackage

// ===== rtl/c2d_pix_if.sv =====
interface c2d_pix_if;
    import c2d_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_value;
    logic drain;

    modport source(output valid, output pixel_value, output drain, input ready);
    modport sink(input valid, input pixel_value, input drain, output ready);

endinterface

// ===== rtl/c2d_res_if.sv =====
interface c2d_res_if;
    import c2d_pkg::*;

    logic valid;
    logic ready;
    t_res filtered_value;
    logic last_pixel;

    modport source(output valid, output filtered_value, output last_pixel, input ready);
    modport sink(input valid, input filtered_value, input last_pixel, output ready);

endinterface

// ===== rtl/c2d_ram.sv =====
module c2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/conv2d_3x3_zero_pad_core.sv =====
// 3x3 true convolution with zero padding over a raster-order pixel stream.
// Input channel i_pix: one word per pixel (signed Q8.8) or a drain word.
// After the last pixel of an image the producer sends width+1 drain words.
// Output channel o_res: one signed Q15.20 sum per image pixel, the final
// one of the image flagged by last_pixel. A result belongs to the pixel
// taken width+1 words earlier.
// Configuration: write image width, height and the three kernel rows through
// i_cfg_we / i_cfg_idx / i_cfg_data while no words are in flight.
// Throughput: one word per cycle while i_pix.ready is high. The line buffer is
// a single-port-read RAM holding two rows side by side, read the cycle a word is
// taken and written back the next; a same-column back-to-back access is forwarded.
// Each result passes the line stage and the cell, product and row-sum registers
// before it enters the output queue, and can leave it on the following cycle.
// Stall: up to 8 results are held; i_pix.ready drops while 8 are pending.
// Reset: width 1024, height 1, zero kernel, position and window cleared.
// The line buffer is not cleared; rows not yet written are masked out.
module conv2d_3x3_zero_pad_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    c2d_pix_if.sink                         i_pix,
    c2d_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import c2d_pkg::*;

    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;
    logic [KROW_W-1:0]  r_kern [KSIZE];

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_pix             r_win [KSIZE][KSIZE];

    logic             r_s1_v;
    logic [COL_W-1:0] r_s1_col;
    t_pix             r_s1_x;
    t_flags           r_s1_f;
    logic             r_s1_wrap;
    logic             r_s1_fwd;
    logic [LINE_W-1:0] r_fwd_data;

    logic r_s2_v, r_s2_last;
    t_pix r_cell [KSIZE][KSIZE];
    logic r_s3_v, r_s3_last;
    t_prod r_prod [KSIZE][KSIZE];
    logic r_s4_v, r_s4_last;
    t_rsum r_rsum [KSIZE];

    t_res              r_fq_val  [FIFO_DEPTH];
    logic              r_fq_last [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PEND_W-1:0] r_cnt, r_pend;

    logic [IMG_W_W-1:0] w_eff, w_dec;
    logic [IMG_H_W-1:0] h_eff;
    logic [COL_W-1:0]   w_m1, col, n_col;
    logic [ROW_W-1:0]   h_row, h_p1, n_row;
    logic               acc, pop, push, col_zero, col_end, in_img, emit_a, emit_b, wrap;
    t_pix               x;
    t_flags             flags;

    logic [LINE_W-1:0] ram_q, line_rd, line_wr;
    t_pix              top, mid;
    t_pix              n_win [KSIZE][KSIZE];
    t_pix              n_cell [KSIZE][KSIZE];
    t_coef             kc [KSIZE][KSIZE];
    t_sum              total;

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = IMG_W_W'(1);
        end else if (r_img_w > IMG_W_W'(MAX_WIDTH)) begin
            w_eff = IMG_W_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == '0) begin
            h_eff = IMG_H_W'(1);
        end else if (r_img_h > IMG_H_W'(MAX_HEIGHT)) begin
            h_eff = IMG_H_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_img_h;
        end
    end

    assign w_dec = w_eff - IMG_W_W'(1);
    assign w_m1  = w_dec[COL_W-1:0];
    assign col   = (IMG_W_W'(r_col) >= w_eff) ? w_m1 : r_col;
    assign h_row = ROW_W'(h_eff);
    assign h_p1  = h_row + ROW_W'(1);

    assign acc      = i_pix.valid && i_pix.ready;
    assign pop      = o_res.valid && o_res.ready;
    assign push     = r_s4_v;
    assign col_zero = (col == '0);
    assign col_end  = (col == w_m1);
    assign in_img   = (r_row < h_row);
    assign x        = (!i_pix.drain && in_img) ? i_pix.pixel_value : '0;
    assign emit_a   = col_zero && (r_row >= ROW_W'(2)) && (r_row <= h_p1);
    assign emit_b   = !col_zero && (r_row != '0) && (r_row <= h_row);

    always_comb begin
        flags.emit    = emit_a || emit_b;
        flags.last    = emit_a && (r_row == h_p1);
        flags.row_end = emit_a;
        flags.m_top   = emit_a ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
        flags.m_bot   = emit_a ? (r_row == h_p1) : (r_row == h_row);
        flags.m_left  = emit_a ? (w_eff == IMG_W_W'(1)) : (col == COL_W'(1));
        n_col = col_end ? '0 : col + COL_W'(1);
        n_row = col_end ? r_row + ROW_W'(1) : r_row;
        wrap  = (n_row > h_p1) || ((n_row == h_p1) && (n_col != '0));
    end

    assign i_pix.ready = (r_pend < PEND_W'(FIFO_DEPTH));

    c2d_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (r_s1_v),
        .i_waddr(r_s1_col),
        .i_wdata(line_wr),
        .i_re   (acc),
        .i_raddr(col),
        .o_rdata(ram_q)
    );

    assign line_rd = r_s1_fwd ? r_fwd_data : ram_q;
    assign top     = line_rd[LINE_W-1:PIX_W];
    assign mid     = line_rd[PIX_W-1:0];
    assign line_wr = {mid, r_s1_x};

    always_comb begin
        for (int a = 0; a < KSIZE; a++) begin
            n_win[a][0] = r_win[a][1];
            n_win[a][1] = r_win[a][2];
        end
        n_win[0][2] = top;
        n_win[1][2] = mid;
        n_win[2][2] = r_s1_x;
        for (int a = 0; a < KSIZE; a++) begin
            for (int b = 0; b < KSIZE; b++) begin
                n_cell[a][b] = n_win[a][b];
                if (b == KSIZE - 1 && r_s1_f.row_end) begin
                    n_cell[a][b] = '0;
                end
                if ((a == 0 && r_s1_f.m_top) || (a == KSIZE - 1 && r_s1_f.m_bot) ||
                    (b == 0 && r_s1_f.m_left)) begin
                    n_cell[a][b] = '0;
                end
                kc[a][b] = $signed(r_kern[KSIZE-1-a][COEF_W*(KSIZE-1-b) +: COEF_W]);
            end
        end
    end

    assign total = SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_W_W'(MAX_WIDTH);
            r_img_h <= IMG_H_W'(1);
            for (int i = 0; i < KSIZE; i++) begin
                r_kern[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMG_WIDTH:  r_img_w   <= i_cfg_data[IMG_W_W-1:0];
                CFG_IMG_HEIGHT: r_img_h   <= i_cfg_data[IMG_H_W-1:0];
                CFG_KERN_TOP:   r_kern[0] <= i_cfg_data;
                CFG_KERN_MID:   r_kern[1] <= i_cfg_data;
                CFG_KERN_BOT:   r_kern[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_s4_v   <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_pend   <= '0;
            for (int a = 0; a < KSIZE; a++) begin
                for (int b = 0; b < KSIZE; b++) begin
                    r_win[a][b] <= '0;
                end
            end
        end else begin
            if (acc) begin
                r_col <= wrap ? '0 : n_col;
                r_row <= wrap ? '0 : n_row;
            end
            if (r_s1_v) begin
                for (int a = 0; a < KSIZE; a++) begin
                    for (int b = 0; b < KSIZE; b++) begin
                        r_win[a][b] <= r_s1_wrap ? '0 : n_win[a][b];
                    end
                end
            end
            r_s1_v <= acc;
            r_s2_v <= r_s1_v && r_s1_f.emit;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FPTR_W'(1);
            end
            r_cnt  <= r_cnt + PEND_W'(push) - PEND_W'(pop);
            r_pend <= r_pend + PEND_W'(acc && flags.emit) - PEND_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col   <= col;
            r_s1_x     <= x;
            r_s1_f     <= flags;
            r_s1_wrap  <= wrap;
            r_s1_fwd   <= r_s1_v && (col == r_s1_col);
            r_fwd_data <= line_wr;
        end
        r_s2_last <= r_s1_f.last;
        r_s3_last <= r_s2_last;
        r_s4_last <= r_s3_last;
        for (int a = 0; a < KSIZE; a++) begin
            for (int b = 0; b < KSIZE; b++) begin
                r_cell[a][b] <= n_cell[a][b];
                r_prod[a][b] <= PROD_W'(r_cell[a][b]) * PROD_W'(kc[a][b]);
            end
            r_rsum[a] <= RSUM_W'(r_prod[a][0]) + RSUM_W'(r_prod[a][1]) +
                         RSUM_W'(r_prod[a][2]);
        end
        if (push) begin
            r_fq_val[r_wr_ptr]  <= $signed(total[RES_W-1:0]);
            r_fq_last[r_wr_ptr] <= r_s4_last;
        end
    end

    assign o_res.valid          = (r_cnt != '0);
    assign o_res.filtered_value = r_fq_val[r_rd_ptr];
    assign o_res.last_pixel     = r_fq_last[r_rd_ptr];

`ifndef ASSERT_OFF
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(FIFO_DEPTH))
        else $error("pending result count above queue depth");

    a_pend_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == r_cnt + PEND_W'(r_s1_v && r_s1_f.emit) + PEND_W'(r_s2_v) +
                  PEND_W'(r_s3_v) + PEND_W'(r_s4_v))
        else $error("pending count out of step with pipeline and queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> (r_cnt < PEND_W'(FIFO_DEPTH)) || pop)
        else $error("push into full result queue");

    a_emit_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && r_s1_f.emit |=> r_s2_v)
        else $error("emitting word lost after line stage");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import c2d_pkg::*;

    localparam int GAP_MAX       = 14;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS  = 400;
    localparam int RESET_RUN     = 48;

    typedef struct {
        t_res value;
        logic last;
    } t_conv_out;

    typedef enum int {PK_RANDOM, PK_EDGES, PK_ALL_MAX, PK_ALL_MIN} t_pix_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    c2d_pix_if pix_ch();
    c2d_res_if res_ch();

    conv2d_3x3_zero_pad_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Convolution state mirrored from the block
    logic [IMG_W_W-1:0] img_w_reg;
    logic [IMG_H_W-1:0] img_h_reg;
    logic [KROW_W-1:0]  kern_reg [KSIZE];
    t_pix               row_buf [2*MAX_WIDTH];
    logic [KSIZE*KSIZE-1:0][PIX_W-1:0] win;
    int unsigned        pos_col;
    int unsigned        pos_row;

    t_conv_out   expected_sums[$];
    int unsigned mismatch_count = 0;
    int unsigned words_sent     = 0;
    int unsigned sums_checked   = 0;
    int unsigned images_sent    = 0;
    logic        tx_calm        = 1'b0;
    logic        rx_calm        = 1'b0;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = 32'(img_w_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = 32'(img_h_reg);
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic t_coef coef_at(int unsigned idx);
        return kern_reg[(idx / KSIZE) % KSIZE][COEF_W * (idx % KSIZE) +: COEF_W];
    endfunction

    // cells[3*a+b]: neighbor at row r-1+a, column c-1+b; kernel is flipped
    function automatic t_res tap_sum(logic [KSIZE*KSIZE-1:0][PIX_W-1:0] cells,
                                     int unsigned r, int unsigned c,
                                     int unsigned w, int unsigned h);
        longint acc;
        acc = 0;
        for (int a = 0; a < KSIZE; a++) begin
            for (int b = 0; b < KSIZE; b++) begin
                if (!(a == 0 && r == 0) && !(a == 2 && r + 1 >= h) &&
                    !(b == 0 && c == 0) && !(b == 2 && c + 1 >= w)) begin
                    acc += longint'($signed(cells[KSIZE*a+b])) *
                           longint'(coef_at(KSIZE * (2 - a) + (2 - b)));
                end
            end
        end
        return acc[RES_W-1:0];
    endfunction

    task automatic predict_word(input t_pix v, input logic drn);
        int unsigned w, h, col, row;
        t_pix x, top_px, mid_px;
        logic [KSIZE*KSIZE-1:0][PIX_W-1:0] cells;
        t_conv_out r;
        w   = eff_width();
        h   = eff_height();
        col = pos_col;
        row = pos_row;
        if (col >= w) col = w - 1;
        x = (!drn && row < h) ? v : '0;

        // row start: finish the last pixel of the row two above
        if (col == 0 && row >= 2 && row <= h + 1) begin
            for (int a = 0; a < KSIZE; a++) begin
                cells[KSIZE*a]   = win[KSIZE*a+1];
                cells[KSIZE*a+1] = win[KSIZE*a+2];
                cells[KSIZE*a+2] = '0;
            end
            r.value = tap_sum(cells, row - 2, w - 1, w, h);
            r.last  = (row == h + 1);
            expected_sums.push_back(r);
        end

        top_px = row_buf[col];
        mid_px = row_buf[MAX_WIDTH+col];
        for (int a = 0; a < KSIZE; a++) begin
            win[KSIZE*a]   = win[KSIZE*a+1];
            win[KSIZE*a+1] = win[KSIZE*a+2];
        end
        win[2] = top_px;
        win[KSIZE+2] = mid_px;
        win[2*KSIZE+2] = x;
        row_buf[col] = mid_px;
        row_buf[MAX_WIDTH+col] = x;

        if (col >= 1 && row >= 1 && row <= h) begin
            r.value = tap_sum(win, row - 1, col - 1, w, h);
            r.last  = 1'b0;
            expected_sums.push_back(r);
        end

        if (col + 1 >= w) begin
            col = 0;
            row++;
        end else begin
            col++;
        end
        if (row > h + 1 || (row == h + 1 && col >= 1)) begin
            col = 0;
            row = 0;
            win = '0;
        end
        pos_col = col;
        pos_row = row;
    endtask

    task automatic send_word(input t_pix v, input logic drn);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) @(negedge i_clk) pix_ch.valid <= 1'b0;
        @(negedge i_clk);
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= v;
        pix_ch.drain       <= drn;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
        predict_word(v, drn);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_IMG_WIDTH: begin
                img_w_reg = data[IMG_W_W-1:0];
            end
            CFG_IMG_HEIGHT: begin
                img_h_reg = data[IMG_H_W-1:0];
            end
            CFG_KERN_TOP: begin
                kern_reg[0] = data;
            end
            CFG_KERN_MID: begin
                kern_reg[1] = data;
            end
            CFG_KERN_BOT: begin
                kern_reg[2] = data;
            end
            default: begin
            end
        endcase
        @(negedge i_clk) cfg_we <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
                             input logic [KROW_W-1:0] bot);
        write_reg(CFG_IMG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMG_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_KERN_TOP, top);
        write_reg(CFG_KERN_MID, mid);
        write_reg(CFG_KERN_BOT, bot);
    endtask

    // Drop valid, wait for every expected sum, then let the pipeline empty
    task automatic settle_stream();
        @(negedge i_clk) pix_ch.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] edge_word16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] kernel_row(input logic edges);
        logic [KROW_W-1:0] k;
        for (int i = 0; i < KSIZE; i++) begin
            k[COEF_W*i +: COEF_W] = edges ? edge_word16() : 16'($urandom);
        end
        return k;
    endfunction

    // One image at the current geometry, followed by its width+1 drain positions
    task automatic send_image(input t_pix_kind kind, input int unsigned drain_pct,
                              input int unsigned noise_pct);
        int unsigned w, h;
        t_pix v;
        w = eff_width();
        h = eff_height();
        for (int unsigned i = 0; i < w * h; i++) begin
            case (kind)
                PK_RANDOM:  v = PIX_W'($urandom);
                PK_EDGES:   v = edge_word16();
                PK_ALL_MAX: v = 16'h7FFF;
                default:    v = 16'h8000;
            endcase
            send_word(v, $urandom_range(1, 100) <= drain_pct);
        end
        for (int unsigned i = 0; i <= w; i++) begin
            send_word(PIX_W'($urandom), $urandom_range(1, 100) > noise_pct);
        end
        images_sent++;
    endtask

    // Send words until the position wraps back to the image start
    task automatic finish_image();
        do begin
            send_word(PIX_W'($urandom), $urandom_range(0, 3) == 0);
        end while (pos_col != 0 || pos_row != 0);
        images_sent++;
    endtask

    task automatic test_reset_geometry();
        write_reg(CFG_KERN_TOP, kernel_row(1'b0));
        write_reg(CFG_KERN_MID, kernel_row(1'b1));
        write_reg(CFG_KERN_BOT, kernel_row(1'b0));
        tx_calm = 1'b1;
        for (int i = 0; i < RESET_RUN; i++) begin
            send_word(PIX_W'($urandom), $urandom_range(1, 100) <= 5);
        end
        settle_stream();
        tx_calm = 1'b0;
        // shrink the geometry mid-row: clamp the column to the new last one
        write_reg(CFG_IMG_WIDTH, CFG_DATA_W'(5));
        write_reg(CFG_IMG_HEIGHT, CFG_DATA_W'(4));
        finish_image();
        settle_stream();
    endtask

    task automatic test_extremes();
        configure(3, 3, {KSIZE{16'h8000}}, {KSIZE{16'h8000}}, {KSIZE{16'h8000}});
        send_image(PK_ALL_MIN, 0, 0);
        settle_stream();
        configure(0, 0, {KSIZE{16'h8000}}, {KSIZE{16'h8000}}, {KSIZE{16'h8000}});
        send_image(PK_ALL_MAX, 0, 100);
        settle_stream();
        configure(2, 2, kernel_row(1'b1), kernel_row(1'b1), kernel_row(1'b1));
        send_image(PK_EDGES, 50, 100);
        settle_stream();
    endtask

    task automatic test_ignored_index();
        for (int k = int'(CFG_KERN_BOT) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), '1);
        end
        send_image(PK_RANDOM, 0, 0);
        settle_stream();
    endtask

    task automatic test_random_images();
        int unsigned goal, w, h;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            if ($urandom_range(0, 9) < 7) begin
                settle_stream();
                case ($urandom_range(0, 9))
                    0: w = 0;
                    1: w = $urandom_range(20, 40);
                    default: w = $urandom_range(1, 8);
                endcase
                h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                configure(w, h, kernel_row(1'($urandom_range(0, 1))),
                          kernel_row(1'($urandom_range(0, 1))),
                          kernel_row(1'($urandom_range(0, 1))));
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            send_image($urandom_range(0, 1) ? PK_RANDOM : PK_EDGES,
                       $urandom_range(0, 1) ? 0 : 10, $urandom_range(0, 1) ? 0 : 25);
        end
        settle_stream();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin
        int unsigned gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
            repeat (gap) @(negedge i_clk) res_ch.ready <= 1'b0;
            @(negedge i_clk) res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    always @(posedge i_clk) begin : check_sums
        t_conv_out want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected sum, expected none, actual %0d last %0b",
                         $time, res_ch.filtered_value, res_ch.last_pixel);
                mismatch_count++;
            end else begin
                want = expected_sums.pop_front();
                sums_checked++;
                if (res_ch.filtered_value !== want.value) begin
                    $display("%0t: filtered_value expected %0d actual %0d",
                             $time, want.value, res_ch.filtered_value);
                    mismatch_count++;
                end
                if (res_ch.last_pixel !== want.last) begin
                    $display("%0t: last_pixel expected %0b actual %0b",
                             $time, want.last, res_ch.last_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_value = '0;
        pix_ch.drain       = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        img_w_reg          = IMG_W_W'(MAX_WIDTH);
        img_h_reg          = IMG_H_W'(1);
        for (int i = 0; i < KSIZE; i++) kern_reg[i] = '0;
        for (int i = 0; i < 2 * MAX_WIDTH; i++) row_buf[i] = '0;
        win     = '0;
        pos_col = 0;
        pos_row = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_geometry();
        test_extremes();
        test_ignored_index();
        test_random_images();

        $display("tb_top: %0d words over %0d images, %0d sums compared, %0d mismatches",
                 words_sent, images_sent, sums_checked, mismatch_count);
        if (mismatch_count == 0 && expected_sums.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/c2d_pkg.sv
rtl/c2d_pix_if.sv
rtl/c2d_res_if.sv
rtl/c2d_ram.sv
rtl/conv2d_3x3_zero_pad_core.sv
tb/tb_top.sv
